@@ src/cmom_pkg.sv @@
// ----------------------------------------------------------------------------
// cmom_pkg
// shared constants, register codes and sequencer states of the color channel
// moments block
// ----------------------------------------------------------------------------
package cmom_pkg;

    // default sizing, handed to the top level parameters
    localparam int MAX_PIXELS_DEF   = 4096;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int MAX_ORDER_DEF    = 4;

    // fixed field widths
    localparam int SAMPLE_W  = 8;
    localparam int VALUE_W   = 17;
    localparam int CHAN_W    = 2;
    localparam int ORDER_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int CC_RAW_W  = 3;
    localparam int PC_RAW_W  = 13;
    localparam int MC_RAW_W  = 3;

    // fixed point
    localparam int MEAN_W  = 24;    // unsigned Q8.16
    localparam int ACC_W   = 64;
    localparam int DEV_W   = 14;    // signed Q9.4
    localparam int MAG_W   = 13;
    localparam int ROOT_W  = 17;
    localparam int BIT_W   = 5;

    // shared multiplier: running power times one factor
    localparam int MUL_A_W = 51;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTS  = 2'd2;

    // register reset values
    localparam logic [CC_RAW_W-1:0] CC_RESET = 3'd3;
    localparam logic [PC_RAW_W-1:0] PC_RESET = 13'd4096;
    localparam logic [MC_RAW_W-1:0] MC_RESET = 3'd3;

    typedef enum logic [4:0] {
        S_LOAD,
        S_MRD,
        S_MACC,
        S_MDIV,
        S_MWAIT,
        S_PRD,
        S_PDEV,
        S_PMUL,
        S_PMWAIT,
        S_PADD,
        S_PDIV,
        S_PWAIT,
        S_RTRY,
        S_RMUL,
        S_RMWAIT,
        S_ROUT,
        S_EMIT
    } t_state;

endpackage

@@ src/cmom_in_if.sv @@
// ----------------------------------------------------------------------------
// cmom_in_if
// sample channel: valid, ready and one 8-bit sample word
// ----------------------------------------------------------------------------
interface cmom_in_if
    import cmom_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ src/cmom_out_if.sv @@
// ----------------------------------------------------------------------------
// cmom_out_if
// result channel: valid, ready and one moment word
// ----------------------------------------------------------------------------
interface cmom_out_if
    import cmom_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic [CHAN_W-1:0]          channel;
    logic [ORDER_W-1:0]         order;
    logic                       last;

    modport source (output valid, output value, output channel, output order,
                    output last, input ready);
    modport sink   (input valid, input value, input channel, input order,
                    input last, output ready);
endinterface

@@ src/cmom_mult.sv @@
// ----------------------------------------------------------------------------
// cmom_mult
// shared multiplier with registered product
// ----------------------------------------------------------------------------
module cmom_mult
    import cmom_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [PROD_W-1:0]  o_prod
);

    logic [PROD_W-1:0] r_prod;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ src/cmom_div.sv @@
// ----------------------------------------------------------------------------
// cmom_div
// restoring divider, one quotient bit per cycle, 64-bit dividend
// ----------------------------------------------------------------------------
module cmom_div
    import cmom_pkg::*;
#(
    parameter int DIV_W = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [ACC_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [ACC_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_dvs, n_dvs;
    logic [DIV_W:0]    trial;

    // one subtract and compare per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_quo[ACC_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DIV_W'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[ACC_W-2:0], 1'b1};
            end else begin
                n_rem = DIV_W'(trial);
                n_quo = {r_quo[ACC_W-2:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(ACC_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ src/color_channel_moments.sv @@
// ----------------------------------------------------------------------------
// color_channel_moments
// per-channel mean and central moments of one image of interleaved samples
// ----------------------------------------------------------------------------
// Samples enter on i_in one word per cycle, channels interleaved pixel by
// pixel, and are written to an internal sample memory. The word that
// completes the image (channel_count times pixel_count words) starts the
// evaluation; i_in.ready stays low until it is done.
// Results leave on o_out, per channel the mean (order 1) then the central
// moments of order 2 up to moment_count, last set on the final word.
// Per channel the mean pass sums the P samples and divides; each higher order
// k adds a sample pass of powers, a divide and a bitwise root search, with P
// the pixel count. The shared multiplier and the one-bit-per-cycle divider
// carry out the products and the divides.
// A stalled receiver holds one result in the output register; the sequencer
// waits at the next result until that word is taken.
// Reset (synchronous, active low) empties the output register, clears the
// sample count and restores channel_count 3, pixel_count 4096,
// moment_count 3. The sample memory is not cleared.
// ----------------------------------------------------------------------------
module color_channel_moments
    import cmom_pkg::*;
#(
    parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_ORDER    = MAX_ORDER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    cmom_in_if.sink              i_in,
    cmom_out_if.source           o_out
);

    localparam int DEPTH = MAX_PIXELS * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PC_W  = $clog2(MAX_PIXELS + 1);
    localparam int CC_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W = SAMPLE_W + PC_W;

    // configuration
    logic [CC_RAW_W-1:0] r_cc_raw;
    logic [PC_RAW_W-1:0] r_pc_raw;
    logic [MC_RAW_W-1:0] r_mc_raw;
    logic [CC_W-1:0]     cc;
    logic [PC_W-1:0]     pc;
    logic [ORDER_W-1:0]  mc;
    logic [CNT_W-1:0]    total;

    // sequencer and datapath
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [AW-1:0]             r_addr, n_addr;
    logic [PC_W-1:0]           r_p, n_p;
    logic [CC_W-1:0]           r_ch, n_ch;
    logic [ORDER_W-1:0]        r_k, n_k;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [MEAN_W-1:0]         r_mean, n_mean;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic [MAG_W-1:0]          r_a, n_a;
    logic                      r_dneg, n_dneg;
    logic [MUL_A_W-1:0]        r_pow, n_pow;
    logic [ORDER_W-1:0]        r_i, n_i;
    logic                      r_neg, n_neg;
    logic [ACC_W-1:0]          r_lim, n_lim;
    logic [ROOT_W-1:0]         r_root, n_root;
    logic [ROOT_W-1:0]         r_c, n_c;
    logic [BIT_W-1:0]          r_bit, n_bit;
    logic [VALUE_W-1:0]        r_val, n_val;

    // output register
    logic                      r_ov;
    logic [VALUE_W-1:0]        r_ovalue;
    logic [CHAN_W-1:0]         r_ochan;
    logic [ORDER_W-1:0]        r_oorder;
    logic                      r_olast;
    logic                      out_load;
    logic                      out_free;

    // sample memory
    logic [SAMPLE_W-1:0]       r_mem [DEPTH];
    logic [SAMPLE_W-1:0]       r_rdata;
    logic                      mem_we;
    logic                      in_acc;

    // shared units
    logic [MUL_B_W-1:0]        mul_b;
    logic [PROD_W-1:0]         prod;
    logic                      div_start;
    logic [ACC_W-1:0]          div_dvd;
    logic                      div_done;
    logic [ACC_W-1:0]          div_q;

    logic signed [DEV_W-1:0]   dev;
    logic [ACC_W-1:0]          mag;
    logic [ROOT_W-1:0]         cand;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_raw <= CC_RESET;
            r_pc_raw <= PC_RESET;
            r_mc_raw <= MC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS: r_cc_raw <= i_cfg_data[CC_RAW_W-1:0];
                CFG_PIXELS:   r_pc_raw <= i_cfg_data[PC_RAW_W-1:0];
                CFG_MOMENTS:  r_mc_raw <= i_cfg_data[MC_RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated settings
    always_comb begin
        if (r_cc_raw == '0)
            cc = CC_W'(1);
        else if (32'(r_cc_raw) > MAX_CHANNELS)
            cc = CC_W'(MAX_CHANNELS);
        else
            cc = CC_W'(r_cc_raw);
        if (r_pc_raw == '0)
            pc = PC_W'(1);
        else if (32'(r_pc_raw) > MAX_PIXELS)
            pc = PC_W'(MAX_PIXELS);
        else
            pc = PC_W'(r_pc_raw);
        if (r_mc_raw == '0)
            mc = ORDER_W'(1);
        else if (32'(r_mc_raw) > MAX_ORDER)
            mc = ORDER_W'(MAX_ORDER);
        else
            mc = ORDER_W'(r_mc_raw);
        total = CNT_W'(cc) * CNT_W'(pc);
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign mem_we   = in_acc && (32'(r_cnt) < DEPTH);
    assign out_free = !r_ov || o_out.ready;

    // sample memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[r_cnt[AW-1:0]] <= i_in.sample;
        r_rdata <= r_mem[r_addr];
    end

    cmom_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (r_pow),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    cmom_div #(
        .DIV_W (PC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (pc),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // sequencer: next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_addr    = r_addr;
        n_p       = r_p;
        n_ch      = r_ch;
        n_k       = r_k;
        n_sum     = r_sum;
        n_mean    = r_mean;
        n_acc     = r_acc;
        n_a       = r_a;
        n_dneg    = r_dneg;
        n_pow     = r_pow;
        n_i       = r_i;
        n_neg     = r_neg;
        n_lim     = r_lim;
        n_root    = r_root;
        n_c       = r_c;
        n_bit     = r_bit;
        n_val     = r_val;
        out_load  = 1'b0;
        div_start = 1'b0;
        div_dvd   = ACC_W'({r_sum, 16'd0});
        mul_b     = (r_state == S_RMUL) ? r_c : MUL_B_W'(r_a);
        dev       = DEV_W'({r_rdata, 4'd0}) - DEV_W'(r_mean[MEAN_W-1:12]);
        mag       = (r_k[0] && r_acc[ACC_W-1]) ? (ACC_W'(0) - r_acc) : r_acc;
        cand      = r_root | (ROOT_W'(1) << r_bit);
        i_in.ready = (r_state == S_LOAD);

        case (r_state)
            // store words until the image is complete
            S_LOAD: begin
                if (in_acc) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 >= total) begin
                        n_cnt  = '0;
                        n_ch   = '0;
                        n_k    = ORDER_W'(1);
                        n_addr = '0;
                        n_p    = '0;
                        n_sum  = '0;
                        n_state = S_MRD;
                    end
                end
            end
            // sum of the channel's samples
            S_MRD: n_state = S_MACC;
            S_MACC: begin
                n_sum = r_sum + SUM_W'(r_rdata);
                if (r_p == pc - 1'b1) begin
                    n_state = S_MDIV;
                end else begin
                    n_p     = r_p + 1'b1;
                    n_addr  = r_addr + AW'(cc);
                    n_state = S_MRD;
                end
            end
            S_MDIV: begin
                div_start = 1'b1;
                n_state   = S_MWAIT;
            end
            S_MWAIT: begin
                if (div_done) begin
                    n_mean  = div_q[MEAN_W-1:0];
                    n_val   = VALUE_W'(div_q[MEAN_W-1:8]);
                    n_state = S_EMIT;
                end
            end
            // power pass: deviation raised to the order
            S_PRD: n_state = S_PDEV;
            S_PDEV: begin
                n_dneg  = dev[DEV_W-1];
                n_a     = dev[DEV_W-1] ? MAG_W'(-dev) : MAG_W'(dev);
                n_pow   = MUL_A_W'(n_a);
                n_i     = ORDER_W'(1);
                n_state = S_PMUL;
            end
            S_PMUL: n_state = S_PMWAIT;
            S_PMWAIT: begin
                n_pow = prod[MUL_A_W-1:0];
                n_i   = r_i + 1'b1;
                if (r_i + 1'b1 == r_k)
                    n_state = S_PADD;
                else
                    n_state = S_PMUL;
            end
            S_PADD: begin
                if (r_dneg && r_k[0])
                    n_acc = r_acc - ACC_W'(r_pow);
                else
                    n_acc = r_acc + ACC_W'(r_pow);
                if (r_p == pc - 1'b1) begin
                    n_state = S_PDIV;
                end else begin
                    n_p     = r_p + 1'b1;
                    n_addr  = r_addr + AW'(cc);
                    n_state = S_PRD;
                end
            end
            // average magnitude, sign kept for odd orders
            S_PDIV: begin
                n_neg     = r_k[0] && r_acc[ACC_W-1];
                div_dvd   = mag;
                div_start = 1'b1;
                n_state   = S_PWAIT;
            end
            S_PWAIT: begin
                if (div_done) begin
                    n_lim   = div_q << {r_k, 2'b00};
                    n_root  = '0;
                    n_bit   = BIT_W'(ROOT_W - 1);
                    n_state = S_RTRY;
                end
            end
            // root search, one candidate bit at a time
            S_RTRY: begin
                n_c     = cand;
                n_pow   = MUL_A_W'(cand);
                n_i     = ORDER_W'(1);
                n_state = S_RMUL;
            end
            S_RMUL: n_state = S_RMWAIT;
            S_RMWAIT: begin
                if (prod > PROD_W'(r_lim) || r_i + 1'b1 == r_k) begin
                    if (prod <= PROD_W'(r_lim))
                        n_root = r_c;
                    if (r_bit == '0) begin
                        n_state = S_ROUT;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_state = S_RTRY;
                    end
                end else begin
                    n_pow   = prod[MUL_A_W-1:0];
                    n_i     = r_i + 1'b1;
                    n_state = S_RMUL;
                end
            end
            S_ROUT: begin
                n_val   = r_neg ? (VALUE_W'(0) - VALUE_W'(r_root)) : VALUE_W'(r_root);
                n_state = S_EMIT;
            end
            // hand the word to the output register, then move on
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_p      = '0;
                    if (r_k < mc) begin
                        n_k     = r_k + 1'b1;
                        n_addr  = AW'(r_ch);
                        n_acc   = '0;
                        n_state = S_PRD;
                    end else if (r_ch < cc - 1'b1) begin
                        n_ch    = r_ch + 1'b1;
                        n_k     = ORDER_W'(1);
                        n_addr  = AW'(r_ch + 1'b1);
                        n_sum   = '0;
                        n_state = S_MRD;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load)
                r_ov <= 1'b1;
            else if (o_out.ready)
                r_ov <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_p    <= n_p;
        r_ch   <= n_ch;
        r_k    <= n_k;
        r_sum  <= n_sum;
        r_mean <= n_mean;
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_dneg <= n_dneg;
        r_pow  <= n_pow;
        r_i    <= n_i;
        r_neg  <= n_neg;
        r_lim  <= n_lim;
        r_root <= n_root;
        r_c    <= n_c;
        r_bit  <= n_bit;
        r_val  <= n_val;
        if (out_load) begin
            r_ovalue <= r_val;
            r_ochan  <= CHAN_W'(r_ch);
            r_oorder <= r_k;
            r_olast  <= (r_ch == cc - 1'b1) && (r_k == mc);
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.value   = r_ovalue;
    assign o_out.channel = r_ochan;
    assign o_out.order   = r_oorder;
    assign o_out.last    = r_olast;

endmodule
